### sv/eidt_pkg.sv
// shared types and constants for the entity id allocator table
// no dependencies
package eidt_pkg;

    localparam int ENTRIES = 1024;
    localparam int ID_W    = $clog2(ENTRIES);
    localparam int CNT_W   = ID_W + 1;

    localparam int ENT_W   = 10;
    localparam int ROW_W   = 32;
    localparam int ARCH_W  = 32;
    localparam int STOR_W  = 16;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_GET    = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BAD_ID = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic signed [ROW_W-1:0] row;
        logic [ARCH_W-1:0]       archetype;
        logic [STOR_W-1:0]       storage;
    } rec_t;

    // commands applied to the id pool when an item completes
    typedef struct packed {
        logic            pop;
        logic            push;
        logic            bump;
        logic [ID_W-1:0] push_id;
    } pool_cmd_t;

    typedef struct packed {
        logic            avail;
        logic            fresh_left;
        logic            push_ok;
        logic [ID_W-1:0] pop_id;
        logic [ID_W-1:0] fresh_id;
    } pool_stat_t;

endpackage

### sv/eidt_rec_mem.sv
// record memory: one write port, one read port with registered data
// depends on eidt_pkg
module eidt_rec_mem (
    input  logic                           clk,
    input  logic                           we,
    input  logic [eidt_pkg::ID_W-1:0]      waddr,
    input  eidt_pkg::rec_t                 wdata,
    input  logic                           re,
    input  logic [eidt_pkg::ID_W-1:0]      raddr,
    output eidt_pkg::rec_t                 rdata
);
    import eidt_pkg::*;

    rec_t mem [ENTRIES];
    rec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/eidt_id_pool.sv
// id pool: lifo free stack memory, its fill count and the fresh id counter
// depends on eidt_pkg
module eidt_id_pool (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd,
    input  eidt_pkg::pool_cmd_t   cmd,
    output eidt_pkg::pool_stat_t  stat
);
    import eidt_pkg::*;

    logic [ID_W-1:0]  stack_mem [ENTRIES];
    logic [ID_W-1:0]  top_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] fresh_reg;
    logic [CNT_W-1:0] fresh_next;
    logic [ID_W-1:0]  top_addr;

    assign top_addr = count_reg[ID_W-1:0] - ID_W'(1);

    // top of stack is fetched when the item is taken in
    always_ff @(posedge clk)
    begin
        if (rd)
        begin
            top_reg <= stack_mem[top_addr];
        end
        if (cmd.push)
        begin
            stack_mem[count_reg[ID_W-1:0]] <= cmd.push_id;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        fresh_next = fresh_reg;
        if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.bump)
        begin
            fresh_next = fresh_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            fresh_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            fresh_reg <= fresh_next;
        end
    end

    assign stat.avail      = (count_reg != '0);
    assign stat.fresh_left = (fresh_reg < CNT_W'(ENTRIES));
    assign stat.push_ok    = (count_reg < CNT_W'(ENTRIES));
    assign stat.pop_id     = top_reg;
    assign stat.fresh_id   = fresh_reg[ID_W-1:0];

endmodule

### sv/entity_id_allocator_table.sv
// Entity id allocator with a per-id record table. A request is taken in and the
// record and free stack memories are read at that edge; when the output register
// is free or being drained, the result is placed in it and the memories are
// written back. in_stall stays high while a request is in flight, so a new beat
// is not taken in until the last one has completed. The output register lets the
// next request be taken in while a result waits. After reset the record memory is
// cleared one entry a cycle, and in_stall stays high until all 1024 entries are
// cleared.
// depends on eidt_pkg, eidt_rec_mem, eidt_id_pool
module entity_id_allocator_table (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          op,
    input  logic [eidt_pkg::ENT_W-1:0]          entity,
    input  logic [eidt_pkg::ARCH_W-1:0]         archetype,
    input  logic signed [eidt_pkg::ROW_W-1:0]   row,
    input  logic [eidt_pkg::STOR_W-1:0]         storage_handle,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [eidt_pkg::ENT_W-1:0]          entity_out,
    output logic signed [eidt_pkg::ROW_W-1:0]   row_out,
    output logic [eidt_pkg::ARCH_W-1:0]         archetype_out,
    output logic [eidt_pkg::STOR_W-1:0]         storage_out,
    output logic                                recycled,
    output logic [1:0]                          status
);
    import eidt_pkg::*;

    logic            clr_reg;
    logic            clr_next;
    logic [ID_W-1:0] clr_cnt_reg;
    logic [ID_W-1:0] clr_cnt_next;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [1:0]       s1_op_reg;
    logic [ENT_W-1:0] s1_ent_reg;
    rec_t             s1_rec_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [ENT_W-1:0] ent_out_reg;
    rec_t             rec_out_reg;
    logic             recyc_reg;
    logic [1:0]       status_reg;

    logic             accept;
    logic             done;
    logic             in_range;

    logic             mem_we;
    logic [ID_W-1:0]  mem_waddr;
    rec_t             mem_wdata;
    rec_t             mem_rdata;
    logic             rec_we;
    rec_t             rec_wdata;

    pool_cmd_t        cmd;
    pool_stat_t       stat;

    logic [ENT_W-1:0] res_ent;
    rec_t             res_rec;
    logic             res_recyc;
    logic [1:0]       res_status;

    assign in_stall = clr_reg | s1_valid_reg;
    assign accept   = in_valid & ~in_stall;
    assign done     = s1_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_range = (32'(s1_ent_reg) < 32'(ENTRIES));

    eidt_rec_mem u_rec_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (entity[ID_W-1:0]),
        .rdata (mem_rdata)
    );

    eidt_id_pool u_id_pool (
        .clk   (clk),
        .rst_n (rst_n),
        .rd    (accept),
        .cmd   (cmd),
        .stat  (stat)
    );

    // resolve the in-flight request
    always_comb
    begin
        res_ent    = s1_ent_reg;
        res_rec    = '0;
        res_recyc  = 1'b0;
        res_status = ST_OK;
        rec_we     = 1'b0;
        rec_wdata  = '0;
        cmd        = '0;
        cmd.push_id = s1_ent_reg[ID_W-1:0];
        case (s1_op_reg)
            OP_ALLOC:
            begin
                if (stat.avail)
                begin
                    res_ent   = ENT_W'(stat.pop_id);
                    res_recyc = 1'b1;
                    cmd.pop   = done;
                end
                else if (!stat.fresh_left)
                begin
                    res_ent    = '0;
                    res_status = ST_FULL;
                end
                else
                begin
                    res_ent  = ENT_W'(stat.fresh_id);
                    cmd.bump = done;
                end
            end
            OP_SET:
            begin
                if (!in_range)
                begin
                    res_status = ST_BAD_ID;
                end
                else
                begin
                    rec_we    = done;
                    rec_wdata = s1_rec_reg;
                end
            end
            OP_REMOVE:
            begin
                if (!in_range)
                begin
                    res_status = ST_BAD_ID;
                end
                else
                begin
                    rec_we   = done;
                    // push is dropped when the stack is already full
                    cmd.push = done & stat.push_ok;
                end
            end
            OP_GET:
            begin
                if (!in_range)
                begin
                    res_status = ST_BAD_ID;
                end
                else
                begin
                    res_rec = mem_rdata;
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    // clearing sweep owns the write port until it ends
    assign mem_we    = clr_reg | rec_we;
    assign mem_waddr = clr_reg ? clr_cnt_reg : s1_ent_reg[ID_W-1:0];
    assign mem_wdata = clr_reg ? rec_t'('0) : rec_wdata;

    always_comb
    begin
        clr_next     = clr_reg;
        clr_cnt_next = clr_cnt_reg;
        if (clr_reg)
        begin
            clr_cnt_next = clr_cnt_reg + ID_W'(1);
            if (clr_cnt_reg == ID_W'(ENTRIES - 1))
            begin
                clr_next = 1'b0;
            end
        end
        s1_valid_next  = accept | (s1_valid_reg & ~done);
        out_valid_next = done | (out_valid_reg & out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= 1'b1;
            clr_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_reg       <= clr_next;
            clr_cnt_reg   <= clr_cnt_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg            <= op;
            s1_ent_reg           <= entity;
            s1_rec_reg.row       <= row;
            s1_rec_reg.archetype <= archetype;
            s1_rec_reg.storage   <= storage_handle;
        end
        if (done)
        begin
            ent_out_reg <= res_ent;
            rec_out_reg <= res_rec;
            recyc_reg   <= res_recyc;
            status_reg  <= res_status;
        end
    end

    assign out_valid     = out_valid_reg;
    assign entity_out    = ent_out_reg;
    assign row_out       = rec_out_reg.row;
    assign archetype_out = rec_out_reg.archetype;
    assign storage_out   = rec_out_reg.storage;
    assign recycled      = recyc_reg;
    assign status        = status_reg;

    a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> !s1_valid_reg && !rec_we && !out_valid_reg)
        else $error("request in flight during clearing sweep");

    a_single_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg && in_stall)
        else $error("accepted beat not held in flight");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_FULL |-> ent_out_reg == '0 && !recyc_reg)
        else $error("table full result carries an id");

    a_recycled_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && recyc_reg |-> status_reg == ST_OK)
        else $error("recycled id with error status");

    a_pool_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.pop, cmd.push, cmd.bump}) <= 1 && (!cmd.pop || done))
        else $error("conflicting id pool commands");

endmodule
